// File: rtl/motor_current_limit_ir_comp_defines.svh
// assertion macros for the motor current limit block
// no dependencies
`ifndef MOTOR_CURRENT_LIMIT_IR_COMP_DEFINES_SVH
`define MOTOR_CURRENT_LIMIT_IR_COMP_DEFINES_SVH
// assertion that holds outside reset
`define MCL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// assertion checked at every edge, reset included
`define MCL_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

// File: rtl/mcl_pkg.sv
// shared types and constants for the motor current limit block
// no dependencies
`timescale 1ns / 1ps
package mcl_pkg;
  localparam logic [16:0] BACK_EMF_CONST_Q8 = 17'd256;
  localparam int QBITS = 15;

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_BOOST = 2'd1,
    MODE_FOLDBACK = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    REG_FOLD_THRESH = 3'd0,
    REG_FOLD_TRIP = 3'd1,
    REG_FOLD_LIMIT = 3'd2,
    REG_COOLDOWN = 3'd3,
    REG_BOOST_CURRENT = 3'd4,
    REG_BOOST_TICKS = 3'd5,
    REG_NORMAL_LIMIT = 3'd6,
    REG_RESISTANCE = 3'd7
  } reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROTECT,
    ST_MUL,
    ST_TARGET,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic signed [15:0] measured_current;
    logic signed [15:0] speed_command;
    logic [15:0] battery_voltage;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] duty;
    logic [1:0] mode;
    logic [14:0] current_limit;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic protect;
    logic mul;
    logic target;
    logic div_start;
    logic div_step;
  } cmd_t;

  typedef struct packed {
    logic div_done;
  } status_t;
endpackage

// File: rtl/mcl_ctrl.sv
// sequencing state machine for the motor current limit block
// depends on mcl_pkg
`timescale 1ns / 1ps
module mcl_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output mcl_pkg::cmd_t cmd,
  input  mcl_pkg::status_t status
);
  mcl_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= mcl_pkg::ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      mcl_pkg::ST_IDLE: if (in_valid) state_next = mcl_pkg::ST_PROTECT;
      mcl_pkg::ST_PROTECT: state_next = mcl_pkg::ST_MUL;
      mcl_pkg::ST_MUL: state_next = mcl_pkg::ST_TARGET;
      mcl_pkg::ST_TARGET: state_next = mcl_pkg::ST_DIV;
      mcl_pkg::ST_DIV: if (status.div_done) state_next = mcl_pkg::ST_OUT;
      mcl_pkg::ST_OUT: if (out_ready) state_next = mcl_pkg::ST_IDLE;
      default: state_next = mcl_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    case (state)
      mcl_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      mcl_pkg::ST_PROTECT: cmd.protect = 1'b1;
      mcl_pkg::ST_MUL: cmd.mul = 1'b1;
      mcl_pkg::ST_TARGET: begin
        cmd.target = 1'b1;
        cmd.div_start = 1'b1;
      end
      mcl_pkg::ST_DIV: cmd.div_step = 1'b1;
      mcl_pkg::ST_OUT: out_valid = 1'b1;
      default: ;
    endcase
  end
endmodule

// File: rtl/mcl_datapath.sv
// protection counters, voltage arithmetic and restoring divider
// depends on mcl_pkg and the defines header
`timescale 1ns / 1ps
`include "motor_current_limit_ir_comp_defines.svh"
module mcl_datapath (
  input  logic clk,
  input  logic rst,
  input  mcl_pkg::in_item_t in_item,
  input  logic cfg_valid,
  input  logic [2:0] cfg_index,
  input  logic [15:0] cfg_data,
  input  mcl_pkg::cmd_t cmd,
  output mcl_pkg::status_t status,
  output mcl_pkg::out_item_t out_item
);
  localparam int QB = mcl_pkg::QBITS;
  logic [14:0] fold_thresh, fold_limit, boost_cur, normal_lim;
  logic [15:0] fold_trip, cooldown, boost_len, res;
  mcl_pkg::mode_t mode, mode_next;
  logic [15:0] fold_cnt, fold_cnt_next, boost_cnt, boost_cnt_next;
  mcl_pkg::in_item_t item;
  logic [14:0] lim;
  logic [16:0] mag;
  logic signed [40:0] demand;
  logic signed [32:0] vmax;
  logic signed [16:0] iapp;
  logic signed [16:0] cur_s, lim_s;
  logic signed [33:0] ir;
  logic signed [41:0] target;
  logic signed [17:0] BK;
  logic [41:0] nabs;
  logic [QB-1:0] num;
  logic [16:0] dvs;
  logic [17:0] rem;
  logic [QB-1:0] quo;
  logic [5:0] cnt;
  logic neg;

  always_ff @(posedge clk) begin
    if (rst) begin
      fold_thresh <= 15'd12800;
      fold_trip <= 16'd2000;
      fold_limit <= 15'd5120;
      cooldown <= 16'd5000;
      boost_cur <= 15'd12800;
      boost_len <= 16'd3000;
      normal_lim <= 15'd10240;
      res <= 16'd6554;
    end else if (cfg_valid) begin
      case (cfg_index)
        mcl_pkg::REG_FOLD_THRESH: fold_thresh <= cfg_data[14:0];
        mcl_pkg::REG_FOLD_TRIP: fold_trip <= cfg_data;
        mcl_pkg::REG_FOLD_LIMIT: fold_limit <= cfg_data[14:0];
        mcl_pkg::REG_COOLDOWN: cooldown <= cfg_data;
        mcl_pkg::REG_BOOST_CURRENT: boost_cur <= cfg_data[14:0];
        mcl_pkg::REG_BOOST_TICKS: boost_len <= cfg_data;
        mcl_pkg::REG_NORMAL_LIMIT: normal_lim <= cfg_data[14:0];
        mcl_pkg::REG_RESISTANCE: res <= cfg_data;
        default: ;
      endcase
    end
  end

  assign mag = item.measured_current[15] ? 17'(-$signed({item.measured_current[15],
                 item.measured_current})) : 17'({1'b0, item.measured_current});

  // protection state update
  always_comb begin
    logic [15:0] inc;
    inc = (fold_cnt == 16'hFFFF) ? fold_cnt : fold_cnt + 16'd1;
    mode_next = mode;
    fold_cnt_next = fold_cnt;
    boost_cnt_next = boost_cnt;
    if (mode != mcl_pkg::MODE_FOLDBACK && mag >= {2'b0, fold_thresh}
        && inc >= fold_trip) begin
      mode_next = mcl_pkg::MODE_FOLDBACK;
      fold_cnt_next = cooldown;
      boost_cnt_next = '0;
    end else begin
      if (mode != mcl_pkg::MODE_FOLDBACK)
        fold_cnt_next = (mag >= {2'b0, fold_thresh}) ? inc : '0;
      case (mode)
        mcl_pkg::MODE_BOOST: begin
          boost_cnt_next = (boost_cnt == 16'hFFFF) ? boost_cnt : boost_cnt + 16'd1;
          if (boost_cnt_next >= boost_len) mode_next = mcl_pkg::MODE_NORMAL;
        end
        mcl_pkg::MODE_FOLDBACK: begin
          if (fold_cnt != '0) fold_cnt_next = fold_cnt - 16'd1;
          else begin
            mode_next = mcl_pkg::MODE_NORMAL;
            boost_cnt_next = '0;
          end
        end
        default: begin
          mode_next = mcl_pkg::MODE_NORMAL;
          if (mag > {2'b0, boost_cur}) begin
            mode_next = mcl_pkg::MODE_BOOST;
            boost_cnt_next = '0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= mcl_pkg::MODE_NORMAL;
      fold_cnt <= '0;
      boost_cnt <= '0;
    end else if (cmd.protect) begin
      mode <= mode_next;
      fold_cnt <= fold_cnt_next;
      boost_cnt <= boost_cnt_next;
    end
  end

  always_comb begin
    case (mode)
      mcl_pkg::MODE_BOOST: lim = boost_cur;
      mcl_pkg::MODE_FOLDBACK: lim = fold_limit;
      default: lim = normal_lim;
    endcase
  end

  // applied current, limited in the drive direction
  assign cur_s = $signed({item.measured_current[15], item.measured_current});
  assign lim_s = $signed({2'b0, lim});
  always_comb begin
    if (item.speed_command[15]) iapp = (cur_s < -lim_s) ? -lim_s : cur_s;
    else iapp = (cur_s > lim_s) ? lim_s : cur_s;
  end

  assign BK = $signed({1'b0, mcl_pkg::BACK_EMF_CONST_Q8});

  always_ff @(posedge clk) begin
    if (cmd.load) item <= in_item;
    if (cmd.protect) demand <= 41'($signed(item.speed_command) * $signed(BK)) <<< 8;
    if (cmd.mul) begin
      vmax <= $signed({2'b0, 31'({15'd0, lim} * {15'd0, res})});
      ir <= 34'(iapp * $signed({1'b0, res}));
    end
  end

  // clamp to half battery, then magnitude and sign for the divider
  always_comb begin
    logic signed [41:0] veff, half, t;
    if (demand > 0)
      veff = ((demand < 41'(vmax)) ? 42'(demand) : 42'(vmax)) + 42'sd8388608;
    else if (demand < 0)
      veff = ((demand > -41'(vmax)) ? 42'(demand) : -42'(vmax)) - 42'sd8388608;
    else veff = '0;
    t = (demand == 0) ? 42'sd0 : veff + 42'(ir);
    half = $signed({11'd0, item.battery_voltage, 15'd0});
    if (t > half) t = half;
    if (t < -half) t = -half;
    target = t;
  end

  assign nabs = 42'(target[41] ? -target : target) + {26'd0, item.battery_voltage};

  // restoring divide of (|target| + vb) by 2 vb, one bit a cycle
  // the quotient stays below 2^15, so the upper bits preload the remainder
  always_ff @(posedge clk) begin
    if (cmd.target) begin
      neg <= target[41];
      rem <= 18'(nabs >> QB);
      num <= nabs[QB-1:0];
      dvs <= {item.battery_voltage, 1'b0};
      quo <= '0;
      cnt <= 6'(QB);
    end else if (cmd.div_step && cnt != '0) begin
      logic [17:0] r2;
      r2 = {rem[16:0], num[QB-1]};
      num <= {num[QB-2:0], 1'b0};
      if (r2 >= {1'b0, dvs}) begin
        rem <= r2 - {1'b0, dvs};
        quo <= {quo[QB-2:0], 1'b1};
      end else begin
        rem <= r2;
        quo <= {quo[QB-2:0], 1'b0};
      end
      cnt <= cnt - 6'd1;
    end
  end

  assign status.div_done = cmd.div_step && (cnt == '0);

  always_comb begin
    out_item.mode = mode;
    out_item.current_limit = lim;
    if (item.battery_voltage == '0) out_item.duty = '0;
    else out_item.duty = neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
  end

  `MCL_ASSERT(a_mode_code, mode != 2'd3, "mode code 3 reached")
  `MCL_ASSERT(a_div_cnt, cnt <= 6'(QB), "divider count out of range")
  `MCL_ASSERT(a_quo_range, !(status.div_done && item.battery_voltage != '0 && quo > 15'd16384), "duty beyond one half")
  `MCL_ASSERT_ALWAYS(a_rst_mode, rst |=> (mode == mcl_pkg::MODE_NORMAL), "mode not normal after reset")
endmodule

// File: rtl/motor_current_limit_ir_comp.sv
// top level of the motor current limit and ir compensation block
// depends on mcl_pkg, mcl_ctrl and mcl_datapath
`timescale 1ns / 1ps
// One tick in, one result out. From input transfer to result transfer a tick
// passes through the protection update, the limit and current multiplies, a
// target step, and a 15-step restoring divider plus a done step; the duty is
// formed from the quotient. The next tick is taken in the cycle after the
// result transfer, so a new tick is never taken before the last result is out.
// Configuration writes take effect at once and belong between ticks.
module motor_current_limit_ir_comp (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  mcl_pkg::in_item_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output mcl_pkg::out_item_t out_data,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [15:0] cfg_data
);
  mcl_pkg::cmd_t cmd;
  mcl_pkg::status_t status;

  assign cfg_ready = 1'b1;

  mcl_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .cmd(cmd), .status(status)
  );

  mcl_datapath u_dp (
    .clk(clk), .rst(rst), .in_item(in_data), .cfg_valid(cfg_valid),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .cmd(cmd), .status(status),
    .out_item(out_data)
  );
endmodule
